@@ rtl/mpe_remap_pkg.sv @@
// Shared types, constants and a helper function of the MPE articulation remap block.
package mpe_remap_pkg;

   // Articulation table geometry.
   localparam int TABLE_DEPTH = 64;
   localparam int CHANNELS    = 16;
   localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_W       = (CNT_W > 7) ? CNT_W : 7;
   localparam int CH_W        = $clog2(CHANNELS);

   // Stream widths.
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 7;

   // Request tdata field offsets.
   localparam int RQ_STATUS_LO = 0;
   localparam int RQ_D1_LO     = 8;
   localparam int RQ_D2_LO     = 15;
   localparam int RQ_LEN_LO    = 22;
   localparam int RQ_AID_LO    = 24;
   localparam int RQ_EIDX_LO   = 40;
   localparam int RQ_EKEY_LO   = 46;
   localparam int RQ_ECHAN_LO  = 62;

   // Item kinds carried in tuser.
   localparam logic [1:0] KIND_EVENT = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Register indexes.
   localparam logic CSR_MPE_ENABLE  = 1'b0;
   localparam logic CSR_TABLE_COUNT = 1'b1;

   // MIDI status decoding.
   localparam logic [7:0] TYPE_MASK     = 8'hF0;
   localparam logic [7:0] CHAN_MASK     = 8'h0F;
   localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
   localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
   localparam logic [7:0] MSG_PRESSURE  = 8'hD0;
   localparam logic [7:0] MSG_BEND      = 8'hE0;
   localparam logic [1:0] LEN_FULL      = 2'd3;
   localparam logic [1:0] LEN_PRESSURE  = 2'd2;
   localparam logic [13:0] BEND_CENTER  = 14'd8192;
   localparam logic [7:0] TRIG_CHAN_MAX = 8'd16;

   typedef struct packed {
      logic        active;
      logic [6:0]  note;
      logic [6:0]  pressure;
      logic [13:0] bend;
   } chan_note_type;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  chan;
   } artic_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } seq_state_type;

   // Per-channel tracking update for one MIDI message.
   function automatic chan_note_type track_update(
      input chan_note_type cur,
      input logic [7:0]    msg_type,
      input logic [6:0]    d1,
      input logic [6:0]    d2,
      input logic [1:0]    len
   );
      chan_note_type nxt;
      logic          long_enough;
      nxt = cur;
      long_enough = (msg_type == MSG_PRESSURE) ? (len >= LEN_PRESSURE) : (len == LEN_FULL);
      if (long_enough) begin
         if (msg_type == MSG_NOTE_ON && d2 != 7'd0) begin
            nxt.active   = 1'b1;
            nxt.note     = d1;
            nxt.pressure = 7'd0;
            nxt.bend     = 14'd0;
         end else if (msg_type == MSG_NOTE_OFF || msg_type == MSG_NOTE_ON) begin
            nxt.active = 1'b0;
         end else if (msg_type == MSG_PRESSURE) begin
            if (cur.active) nxt.pressure = d1;
         end else if (msg_type == MSG_BEND) begin
            if (cur.active) nxt.bend = {d2, d1} - BEND_CENTER;
         end
      end
      return nxt;
   endfunction

endpackage

@@ rtl/mpe_remap_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module mpe_remap_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/midi_mpe_tracker_articulation_remap_core.sv @@
// Top level of the MPE per-channel note tracker with articulation channel remap.
// Load, clear and ignored items are done at acceptance; a MIDI event goes to the response
//    stage, after a remap search through the table when one runs, and its result is registered there.
// An event is accepted only from idle, so a new event waits until the last result is registered;
//    the search reads one table entry a cycle, and a result held back by rsp_tready stalls the next event.
// Reset: synchronous, active high; clears notes, registers and sequencer but not the table.
module midi_mpe_tracker_articulation_remap_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // From bit 0: status_byte[8], data_one[7], data_two[7], msg_length[2], artic_id[16],
   // entry_index[6], entry_key[16], entry_channel[8], two zero pad bits.
   input  logic [mpe_remap_pkg::REQ_DATA_W-1:0] req_tdata,
   // From bit 0: kind[2].
   input  logic [mpe_remap_pkg::REQ_USER_W-1:0] req_tuser,
   // Response stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // From bit 0: status_out[8], data_one_out[7], data_two_out[7], note_active[1],
   // note_number[7], pressure_raw[7], bend_offset[14], five zero pad bits.
   output logic [mpe_remap_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Register write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [mpe_remap_pkg::CSR_DATA_W-1:0] csr_data
);

   import mpe_remap_pkg::*;

   // Request field decode.
   logic [1:0]  rq_kind;
   logic [7:0]  rq_status;
   logic [6:0]  rq_d1;
   logic [6:0]  rq_d2;
   logic [1:0]  rq_len;
   logic [15:0] rq_aid;
   logic [5:0]  rq_eidx;
   logic [15:0] rq_ekey;
   logic [7:0]  rq_echan;

   assign rq_kind   = req_tuser[1:0];
   assign rq_status = req_tdata[RQ_STATUS_LO +: 8];
   assign rq_d1     = req_tdata[RQ_D1_LO +: 7];
   assign rq_d2     = req_tdata[RQ_D2_LO +: 7];
   assign rq_len    = req_tdata[RQ_LEN_LO +: 2];
   assign rq_aid    = req_tdata[RQ_AID_LO +: 16];
   assign rq_eidx   = req_tdata[RQ_EIDX_LO +: 6];
   assign rq_ekey   = req_tdata[RQ_EKEY_LO +: 16];
   assign rq_echan  = req_tdata[RQ_ECHAN_LO +: 8];

   // Sequencer and event registers.
   seq_state_type state_ff, state_in;
   logic          enable_ff, enable_in;
   logic [6:0]    count_cfg_ff, count_cfg_in;
   logic [7:0]    ev_status_ff, ev_status_in;
   logic [6:0]    ev_d1_ff, ev_d1_in;
   logic [6:0]    ev_d2_ff, ev_d2_in;
   logic [15:0]   ev_aid_ff, ev_aid_in;
   logic [CH_W-1:0] ev_ch_ff, ev_ch_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   chan_note_type notes_ff [CHANNELS];
   chan_note_type notes_in [CHANNELS];

   // Articulation table port signals.
   logic            ram_we;
   logic            ram_re;
   logic [TBL_AW-1:0] ram_waddr;
   logic [TBL_AW-1:0] ram_raddr;
   artic_entry_type ram_wdata;
   artic_entry_type ram_rdata;
   logic [23:0]     ram_rdata_raw;

   // Helper values.
   logic [CNT_W-1:0] count_sat;
   logic             idx_in_range;
   logic             entry_hit;
   logic [7:0]       ev_type;
   logic [7:0]       rq_type;
   logic [CH_W-1:0]  rq_ch;
   logic [7:0]       trig_chan_m1;
   chan_note_type    rep_note;

   assign ram_rdata    = artic_entry_type'(ram_rdata_raw);
   assign req_tready   = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign ev_type      = ev_status_ff & TYPE_MASK;
   assign rq_type      = rq_status & TYPE_MASK;
   assign rq_ch        = rq_status[CH_W-1:0];
   assign trig_chan_m1 = ram_rdata.chan - 8'd1;
   assign rep_note     = notes_ff[ev_ch_ff];

   // The register count saturates at the table depth.
   assign count_sat = (LIM_W'(count_cfg_ff) > LIM_W'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(count_cfg_ff);
   assign idx_in_range = (32'(rq_eidx) < 32'(TABLE_DEPTH));

   // A read issued last cycle shows its entry now; it hits on a matching key with a trigger
   // channel from 1 to 16.
   assign entry_hit = pend_ff && (ram_rdata.key == ev_aid_ff) &&
                      (ram_rdata.chan != 8'd0) && (ram_rdata.chan <= TRIG_CHAN_MAX);

   assign ram_waddr = TBL_AW'(rq_eidx);
   assign ram_wdata = '{key: rq_ekey, chan: rq_echan};
   assign ram_raddr = issue_ff[TBL_AW-1:0];

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      count_cfg_in = count_cfg_ff;
      ev_status_in = ev_status_ff;
      ev_d1_in     = ev_d1_ff;
      ev_d2_in     = ev_d2_ff;
      ev_aid_in    = ev_aid_ff;
      ev_ch_in     = ev_ch_ff;
      limit_in     = limit_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      rsp_data_in  = rsp_data_ff;
      notes_in     = notes_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      // A waiting response leaves once it is taken.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // The user must write the registers only while the block is idle; the block itself does not enforce it.
      if (csr_valid) begin
         case (csr_index)
            CSR_MPE_ENABLE:  enable_in    = csr_data[0];
            CSR_TABLE_COUNT: count_cfg_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (rq_kind)
                  KIND_EVENT: begin
                     ev_status_in = rq_status;
                     ev_d1_in     = rq_d1;
                     ev_d2_in     = rq_d2;
                     ev_aid_in    = rq_aid;
                     ev_ch_in     = rq_ch;
                     limit_in     = count_sat;
                     issue_in     = '0;
                     pend_in      = 1'b0;
                     // Tracking is applied at acceptance; the search never touches notes.
                     if (enable_ff) begin
                        notes_in[rq_ch] = track_update(notes_ff[rq_ch], rq_type, rq_d1,
                                                       rq_d2, rq_len);
                     end
                     if (count_sat != '0 && rq_len == LEN_FULL && rq_aid != 16'd0) begin
                        state_in = ST_SEARCH;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  KIND_LOAD: begin
                     ram_we = idx_in_range;
                  end
                  KIND_CLEAR: begin
                     for (int c = 0; c < CHANNELS; c++) notes_in[CH_W'(c)] = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            // Keep one read in flight ahead of the compare.
            if (issue_ff != limit_ff) begin
               ram_re   = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (entry_hit) begin
               // Only note-on and note-off take the trigger channel; any hit ends the search.
               if (ev_type == MSG_NOTE_ON || ev_type == MSG_NOTE_OFF) begin
                  ev_status_in = ev_type | (trig_chan_m1 & CHAN_MASK);
               end
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end else if (issue_ff == limit_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = RSP_DATA_W'({rep_note.bend, rep_note.pressure, rep_note.note,
                                           rep_note.active, ev_d2_ff, ev_d1_ff, ev_status_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         count_cfg_ff <= '0;
         pend_ff      <= 1'b0;
         issue_ff     <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) notes_ff[CH_W'(c)] <= '0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         count_cfg_ff <= count_cfg_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         notes_ff     <= notes_in;
      end
      ev_status_ff <= ev_status_in;
      ev_d1_ff     <= ev_d1_in;
      ev_d2_ff     <= ev_d2_in;
      ev_aid_ff    <= ev_aid_in;
      ev_ch_ff     <= ev_ch_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Articulation table: written by load items, read one entry a cycle by the search.
   mpe_remap_ram #(
      .WIDTH (24),
      .DEPTH (TABLE_DEPTH)
   ) u_artic_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (24'(ram_wdata)),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

`ifndef SYNTHESIS
   // An accepted MIDI event always starts the search or the response stage.
   a_event_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rq_kind == KIND_EVENT) |=> (state_ff != ST_IDLE))
      else $error("accepted event did not leave idle");

   // The read pointer never runs past the saturated entry count.
   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (issue_ff <= limit_ff))
      else $error("search read pointer beyond entry count");

   // A new response only appears out of the response stage.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the response stage");

   // The table is never written while a search reads it.
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> !ram_we)
      else $error("table write during search");
`endif

endmodule

@@ sim/midi_mpe_tracker_articulation_remap_core_tb.sv @@
// Self-checking testbench of the MPE note tracker with articulation channel remap.
module midi_mpe_tracker_articulation_remap_core_tb;
   import mpe_remap_pkg::*;

   // Kind code that the block must drop without a result.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Run limits. The slowest legal event is one that searches the whole table, and every
   // transaction may see a long sender gap and a long receiver stall.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_WAIT  = TABLE_DEPTH + 8;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_ITEMS  = 200;
   localparam int MAX_MISMATCH_LINES = 30;

   // One request transaction, unpacked.
   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  status;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic [1:0]  msg_len;
      logic [15:0] artic_id;
      logic [5:0]  entry_index;
      logic [15:0] entry_key;
      logic [7:0]  entry_chan;
   } midi_item_type;

   // The channel report that one MIDI event must return.
   typedef struct packed {
      logic [7:0]  status;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic        active;
      logic [6:0]  note;
      logic [6:0]  pressure;
      logic [13:0] bend;
   } tracker_report_type;

   // The scoreboard keeps its own copy of the per-channel note state, the articulation
   // table and both registers. It predicts one report per accepted MIDI event and
   // compares each delivered result with the oldest report still pending.
   class tracker_scoreboard;
      chan_note_type   chan_notes[CHANNELS];
      artic_entry_type artic_slots[TABLE_DEPTH];
      bit              tracking_on;
      logic [6:0]      slots_in_use;
      tracker_report_type pending_reports[$];
      int              error_count;
      int              mismatch_lines;
      int              events_noted;
      int              loads_noted;
      int              clears_noted;
      int              remaps_noted;

      function new();
         foreach (chan_notes[i]) chan_notes[i] = '0;
         foreach (artic_slots[i]) artic_slots[i] = '0;
         tracking_on    = 1'b0;
         slots_in_use   = '0;
         error_count    = 0;
         mismatch_lines = 0;
         events_noted   = 0;
         loads_noted    = 0;
         clears_noted   = 0;
         remaps_noted   = 0;
      endfunction

      function void write_register(logic idx, logic [6:0] value);
         if (idx == CSR_MPE_ENABLE) begin
            tracking_on = value[0];
         end else begin
            slots_in_use = value;
         end
      endfunction

      // Printing is capped so that a badly broken block cannot flood the log.
      task report_mismatch(string what, int got, int want);
         error_count++;
         if (mismatch_lines < MAX_MISMATCH_LINES) begin
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
            mismatch_lines++;
         end
      endtask

      function void note_request(midi_item_type it);
         tracker_report_type rep;
         chan_note_type   cn;
         logic [7:0]      msg_type;
         logic [3:0]      ch;
         bit              long_enough;
         bit              hit;
         int              limit;
         case (it.kind)
            KIND_LOAD: begin
               artic_slots[it.entry_index].key  = it.entry_key;
               artic_slots[it.entry_index].chan = it.entry_chan;
               loads_noted++;
            end
            KIND_CLEAR: begin
               foreach (chan_notes[i]) chan_notes[i] = '0;
               clears_noted++;
            end
            KIND_EVENT: begin
               msg_type = it.status & TYPE_MASK;
               ch       = it.status[3:0];
               cn       = chan_notes[ch];
               if (msg_type == MSG_PRESSURE) long_enough = (it.msg_len >= LEN_PRESSURE);
               else long_enough = (it.msg_len == LEN_FULL);
               if (tracking_on && long_enough) begin
                  case (msg_type)
                     MSG_NOTE_ON: begin
                        if (it.data_two != 7'd0) begin
                           cn.active   = 1'b1;
                           cn.note     = it.data_one;
                           cn.pressure = 7'd0;
                           cn.bend     = 14'd0;
                        end else begin
                           cn.active = 1'b0;
                        end
                     end
                     MSG_NOTE_OFF: cn.active = 1'b0;
                     MSG_PRESSURE: if (cn.active) cn.pressure = it.data_one;
                     MSG_BEND:     if (cn.active) cn.bend = {it.data_two, it.data_one} + 14'h2000;
                     default: ;
                  endcase
                  chan_notes[ch] = cn;
               end

               // Search the table for the first usable entry with this key. A hit on a
               // message other than note-on or note-off still ends the search.
               rep.status = it.status;
               limit = (slots_in_use > TABLE_DEPTH) ? TABLE_DEPTH : slots_in_use;
               hit   = 1'b0;
               if (limit != 0 && it.msg_len == LEN_FULL && it.artic_id != 16'd0) begin
                  for (int i = 0; i < limit && !hit; i++) begin
                     if (artic_slots[TBL_AW'(i)].key == it.artic_id &&
                         artic_slots[TBL_AW'(i)].chan != 8'd0 &&
                         artic_slots[TBL_AW'(i)].chan <= TRIG_CHAN_MAX) begin
                        hit = 1'b1;
                        if (msg_type == MSG_NOTE_ON || msg_type == MSG_NOTE_OFF)
                           rep.status = msg_type |
                                        ((artic_slots[TBL_AW'(i)].chan - 8'd1) & CHAN_MASK);
                     end
                  end
               end
               if (rep.status != it.status) remaps_noted++;

               rep.data_one = it.data_one;
               rep.data_two = it.data_two;
               rep.active   = cn.active;
               rep.note     = cn.note;
               rep.pressure = cn.pressure;
               rep.bend     = cn.bend;
               pending_reports.push_back(rep);
               events_noted++;
            end
            default: ;
         endcase
      endfunction

      task check_response(logic [RSP_DATA_W-1:0] word);
         tracker_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch("result with nothing pending, status_out", 32'(word[7:0]), 0);
         end else begin
            want = pending_reports.pop_front();
            if (word[7:0] !== want.status)
               report_mismatch("status_out", 32'(word[7:0]), 32'(want.status));
            if (word[14:8] !== want.data_one)
               report_mismatch("data_one_out", 32'(word[14:8]), 32'(want.data_one));
            if (word[21:15] !== want.data_two)
               report_mismatch("data_two_out", 32'(word[21:15]), 32'(want.data_two));
            if (word[22] !== want.active)
               report_mismatch("note_active", 32'(word[22]), 32'(want.active));
            if (word[29:23] !== want.note)
               report_mismatch("note_number", 32'(word[29:23]), 32'(want.note));
            if (word[36:30] !== want.pressure)
               report_mismatch("pressure_raw", 32'(word[36:30]), 32'(want.pressure));
            if (word[50:37] !== want.bend)
               report_mismatch("bend_offset", 32'(word[50:37]), 32'(want.bend));
         end
      endtask
   endclass

   // Clock, reset and every block input start at known values.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic                  csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   tracker_scoreboard tracker = new();

   // Control between the stimulus process and the receiver process. Each variable has a
   // single writer: idle_off and holds_asked belong to the stimulus, holds_served to the
   // receiver.
   bit idle_off     = 1'b0;
   int holds_asked  = 0;
   int holds_served = 0;
   int items_sent   = 0;
   int cycle_count  = 0;

   midi_mpe_tracker_articulation_remap_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Reset is held at the start and never raised again.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               tracker.pending_reports.size());
      $display("midi_mpe_tracker_articulation_remap_core_tb failed");
      $finish;
   end

   // Idle length for either side: mostly none, sometimes a few cycles, rarely a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_off || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Keys come mostly from a small pool so that events often find a table entry.
   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 9) == 0) return 16'hFFFF;
      return 16'($urandom_range(1, 12));
   endfunction

   // Trigger channels are mostly valid; the rest cover zero and out-of-range values.
   function automatic logic [7:0] pick_trigger_chan();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 8'($urandom_range(1, 16));
      if (r < 85) return 8'd0;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(midi_item_type it);
      logic [REQ_DATA_W-1:0] w;
      w = '0;
      w[RQ_STATUS_LO +: 8] = it.status;
      w[RQ_D1_LO     +: 7] = it.data_one;
      w[RQ_D2_LO     +: 7] = it.data_two;
      w[RQ_LEN_LO    +: 2] = it.msg_len;
      w[RQ_AID_LO    +: 16] = it.artic_id;
      w[RQ_EIDX_LO   +: 6] = it.entry_index;
      w[RQ_EKEY_LO   +: 16] = it.entry_key;
      w[RQ_ECHAN_LO  +: 8] = it.entry_chan;
      return w;
   endfunction

   // Random transaction. Fields that the kind does not use carry random noise, so every
   // bit of every field toggles.
   function automatic midi_item_type random_item();
      midi_item_type it;
      logic [3:0] ch;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 8) it.kind = KIND_LOAD;
      else if (r < 10) it.kind = KIND_CLEAR;
      else if (r < 12) it.kind = KIND_SPARE;
      else it.kind = KIND_EVENT;

      // Half of the events land on four channels so that notes stay active long enough
      // for pressure and bend to find them.
      ch = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      r  = $urandom_range(0, 99);
      if (r < 35) it.status = MSG_NOTE_ON | ch;
      else if (r < 50) it.status = MSG_NOTE_OFF | ch;
      else if (r < 65) it.status = MSG_PRESSURE | ch;
      else if (r < 80) it.status = MSG_BEND | ch;
      else it.status = 8'($urandom_range(0, 255));
      it.data_one = 7'($urandom_range(0, 127));
      it.data_two = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
      it.msg_len  = ($urandom_range(0, 99) < 80) ? LEN_FULL : 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 30) it.artic_id = 16'd0;
      else if (r < 85) it.artic_id = pick_key();
      else it.artic_id = 16'($urandom_range(0, 65535));
      it.entry_index = 6'($urandom_range(0, TABLE_DEPTH - 1));
      it.entry_key   = ($urandom_range(0, 99) < 80) ? pick_key() :
                       16'($urandom_range(0, 65535));
      it.entry_chan  = pick_trigger_chan();
      return it;
   endfunction

   // Offers one transaction and waits for the handshake. The valid stays high on return,
   // so a back-to-back transaction keeps it up without a glitch.
   task automatic send_item(input midi_item_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= pack_request(it);
      do @(posedge clock); while (!req_tready);
      tracker.note_request(it);
      if (it.kind != KIND_SPARE) items_sent++;
   endtask

   task automatic idle_sender();
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_event(input logic [7:0] status, input logic [6:0] d1,
                             input logic [6:0] d2, input logic [1:0] len,
                             input logic [15:0] aid);
      midi_item_type it;
      it          = random_item();
      it.kind     = KIND_EVENT;
      it.status   = status;
      it.data_one = d1;
      it.data_two = d2;
      it.msg_len  = len;
      it.artic_id = aid;
      send_item(it);
      idle_sender();
   endtask

   task automatic send_load(input logic [5:0] idx, input logic [15:0] key,
                            input logic [7:0] chan);
      midi_item_type it;
      it             = random_item();
      it.kind        = KIND_LOAD;
      it.entry_index = idx;
      it.entry_key   = key;
      it.entry_chan  = chan;
      send_item(it);
      idle_sender();
   endtask

   task automatic send_kind(input logic [1:0] kind);
      midi_item_type it;
      it      = random_item();
      it.kind = kind;
      send_item(it);
      idle_sender();
   endtask

   // Stops offering, waits until every pending report has come back, then lets the
   // given number of cycles pass so that any table search has surely finished.
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Writes both registers back to back; only called while the block is idle.
   task automatic configure(input logic enable, input logic [6:0] count);
      csr_valid <= 1'b1;
      csr_index <= CSR_MPE_ENABLE;
      csr_data  <= {6'd0, enable};
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(CSR_MPE_ENABLE, {6'd0, enable});
      csr_index <= CSR_TABLE_COUNT;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(CSR_TABLE_COUNT, count);
      csr_valid <= 1'b0;
   endtask

   // Receiver: checks every result transaction and drives the ready with random stalls.
   // A long hold-off requested by the stimulus is counted down here, in its own process,
   // so that the sender keeps offering while the block backs up.
   initial begin : result_side
      int stall_left;
      int hold_left;
      int n;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
         if (holds_served != holds_asked) begin
            hold_left = LONG_HOLD;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               stall_left = n - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Stimulus.
   initial begin : stimulus
      midi_item_type it;
      logic       phase_enable[6];
      logic [6:0] phase_count[6];
      int         n;

      phase_enable = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      phase_count  = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd0, 7'd100};
      phase_count[4] = 7'($urandom_range(2, TABLE_DEPTH - 1));

      while (reset) @(posedge clock);
      configure(1'b1, 7'd0);

      // Fill the whole table before any search can run, so no search ever reads an
      // unwritten slot. The first slots are set up for the directed remap cases: two
      // invalid entries with key 5 ahead of a valid one, and a key found only in the
      // last slot.
      send_load(6'd0, 16'd5, 8'd0);
      send_load(6'd1, 16'd5, 8'd17);
      send_load(6'd2, 16'd5, 8'd16);
      send_load(6'd3, 16'd5, 8'd1);
      send_load(6'd4, 16'hFFFF, 8'd8);
      for (int i = 5; i < TABLE_DEPTH - 1; i++) send_load(6'(i), pick_key(), pick_trigger_chan());
      send_load(6'(TABLE_DEPTH - 1), 16'hBEEF, 8'd1);

      settle(SETTLE_WAIT);
      configure(1'b1, 7'd64);

      // Directed tracking cases on channel 0: note-on, full-scale pressure and bend,
      // bend at its lowest, short messages that must be ignored.
      send_event(MSG_NOTE_ON | 8'h0, 7'd127, 7'd127, LEN_FULL, 16'd0);
      send_event(MSG_PRESSURE | 8'h0, 7'd127, 7'd0, LEN_PRESSURE, 16'd0);
      send_event(MSG_BEND | 8'h0, 7'd127, 7'd127, LEN_FULL, 16'd0);
      send_event(MSG_BEND | 8'h0, 7'd0, 7'd0, LEN_FULL, 16'd0);
      send_event(MSG_PRESSURE | 8'h0, 7'd5, 7'd0, 2'd1, 16'd0);
      send_event(MSG_NOTE_ON | 8'h0, 7'd3, 7'd9, LEN_PRESSURE, 16'd0);
      // Pressure and bend on a channel with no note are dropped.
      send_event(MSG_PRESSURE | 8'h1, 7'd77, 7'd0, LEN_FULL, 16'd0);
      send_event(MSG_BEND | 8'h1, 7'd1, 7'd99, LEN_FULL, 16'd0);
      // Note-on with zero velocity releases the note.
      send_event(MSG_NOTE_ON | 8'h0, 7'd127, 7'd0, LEN_FULL, 16'd0);
      send_event(MSG_NOTE_ON | 8'hF, 7'd0, 7'd1, LEN_FULL, 16'd0);
      send_event(MSG_NOTE_OFF | 8'hF, 7'd0, 7'd64, LEN_FULL, 16'd0);
      // Untracked message types pass straight through.
      send_event(8'hB3, 7'd7, 7'd100, LEN_FULL, 16'd5);
      send_event(8'hFF, 7'd127, 7'd127, LEN_FULL, 16'd0);
      // Remap: key 5 skips two invalid entries and lands on trigger channel 16.
      send_event(MSG_NOTE_ON | 8'h3, 7'd60, 7'd90, LEN_FULL, 16'd5);
      send_event(MSG_NOTE_OFF | 8'h3, 7'd60, 7'd0, LEN_FULL, 16'd5);
      send_event(MSG_NOTE_ON | 8'h4, 7'd61, 7'd90, LEN_FULL, 16'hBEEF);
      // A short note message is neither tracked nor remapped; pressure is never remapped.
      send_event(MSG_NOTE_ON | 8'h5, 7'd62, 7'd90, LEN_PRESSURE, 16'd5);
      send_event(MSG_PRESSURE | 8'h3, 7'd44, 7'd0, LEN_FULL, 16'd5);
      send_event(MSG_NOTE_ON | 8'h6, 7'd63, 7'd90, LEN_FULL, 16'h1234);
      send_event(MSG_NOTE_ON | 8'h7, 7'd64, 7'd90, LEN_FULL, 16'hFFFF);
      // An unknown kind is dropped; a clear wipes every channel.
      send_kind(KIND_SPARE);
      send_kind(KIND_CLEAR);
      send_event(MSG_PRESSURE | 8'h7, 7'd12, 7'd0, LEN_FULL, 16'd0);

      // With tracking off the state is only reported. A count past the table depth
      // saturates, so the key in the last slot is still found.
      settle(SETTLE_WAIT);
      configure(1'b0, 7'd127);
      send_event(MSG_NOTE_ON | 8'h2, 7'd50, 7'd80, LEN_FULL, 16'hBEEF);
      send_event(MSG_NOTE_OFF | 8'h2, 7'd50, 7'd80, LEN_FULL, 16'hBEEF);

      // With one slot in use, key 5 only meets an invalid entry.
      settle(SETTLE_WAIT);
      configure(1'b1, 7'd1);
      send_event(MSG_NOTE_ON | 8'h8, 7'd70, 7'd70, LEN_FULL, 16'd5);

      // Random phases, each with its own register setting. Phase 1 runs without any
      // idling, phase 3 holds the result side off for a long stretch, and phase 4
      // drains the block completely in the middle.
      for (int p = 0; p < 6; p++) begin
         settle(SETTLE_WAIT);
         configure(phase_enable[p], phase_count[p]);
         idle_off = (p == 1);
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (p == 3 && n == 20) holds_asked++;
            if (p == 4 && n == PHASE_ITEMS / 2) settle(0);
            it = random_item();
            send_item(it);
            if (it.kind != KIND_SPARE) n++;
            idle_sender();
         end
      end
      idle_off = 1'b0;

      settle(SETTLE_WAIT);
      $display("Sent %0d transactions: %0d MIDI events, %0d table loads, %0d note clears.",
               items_sent, tracker.events_noted, tracker.loads_noted, tracker.clears_noted);
      $display("%0d events had their channel rewritten; %0d mismatches seen.",
               tracker.remaps_noted, tracker.error_count);
      if (tracker.error_count == 0) begin
         $display("midi_mpe_tracker_articulation_remap_core_tb passed");
      end else begin
         $display("midi_mpe_tracker_articulation_remap_core_tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/mpe_remap_pkg.sv
rtl/mpe_remap_ram.sv
rtl/midi_mpe_tracker_articulation_remap_core.sv
sim/midi_mpe_tracker_articulation_remap_core_tb.sv
